/* hdl/nvi_pkg.sv */
// shared types, constants and helpers for the neville interpolator
package nvi_pkg;

  localparam int unsigned DATA_W         = 32;
  localparam int unsigned MAX_POINTS_DEF = 8;
  localparam int unsigned PC_W           = 4;
  localparam logic [PC_W-1:0] PC_RESET   = 4'd4;
  localparam int unsigned SLOT_W         = 3;
  localparam int unsigned REG_POINT_COUNT = 0;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic start;
    logic srch;
    logic init;
    logic rd_a;
    logic rd_b;
    logic rd_c;
    logic zero;
    logic mul;
    logic mul_hl;
    logic div_start;
    logic wr_d;
    logic wr_c;
    logic y_upd;
    logic out_load;
  } nvi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic div_busy;
  } nvi_sts_t;

  // saturate a 33-bit signed value into 32 bits
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] v);
    logic [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic ovf33(input logic [DATA_W:0] v);
    return v[DATA_W] ^ v[DATA_W-1];
  endfunction

endpackage

/* hdl/nvi_if.sv */
// stream interfaces for query/load items and results
interface nvi_in_if;
  import nvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [SLOT_W-1:0]        point_index;
  logic signed [DATA_W-1:0] x_value;
  logic signed [DATA_W-1:0] y_value;
  modport source (output valid, req_type, point_index, x_value, y_value, input ready);
  modport sink   (input valid, req_type, point_index, x_value, y_value, output ready);
endinterface

interface nvi_out_if;
  import nvi_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] y_result;
  logic                     error_flag;
  modport source (output valid, y_result, error_flag, input ready);
  modport sink   (input valid, y_result, error_flag, output ready);
endinterface

/* hdl/nvi_div.sv */
// iterative signed divider, 64 by 33 bits, one quotient bit per cycle, saturated to 32 bits
module nvi_div
  import nvi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [63:0]       dividend,
  input  logic signed [DATA_W:0]   divisor,
  output logic                     busy,
  output logic                     done,
  output logic [DATA_W-1:0]        quotient,
  output logic                     ovf
);

  logic [63:0]     a_r, a_nxt;
  logic [DATA_W:0] b_r;
  logic [DATA_W:0] rem_r, rem_nxt;
  logic            neg_r;
  logic [5:0]      cnt_r;
  logic            busy_r, done_r;
  logic [DATA_W+1:0] shifted, diff;

  assign shifted = {rem_r, a_r[63]};
  assign diff    = shifted - {1'b0, b_r};

  always_comb begin
    if (!diff[DATA_W+1]) begin
      rem_nxt = diff[DATA_W:0];
      a_nxt   = {a_r[62:0], 1'b1};
    end else begin
      rem_nxt = shifted[DATA_W:0];
      a_nxt   = {a_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend[63] ? -dividend : dividend;
      b_r   <= divisor[DATA_W] ? -divisor : divisor;
      neg_r <= dividend[63] ^ divisor[DATA_W];
      rem_r <= '0;
    end else if (busy_r) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  // magnitude in a_r, sign applied with saturation
  always_comb begin
    ovf      = 1'b0;
    quotient = neg_r ? -a_r[DATA_W-1:0] : a_r[DATA_W-1:0];
    if (!neg_r && (a_r > 64'h0000_0000_7FFF_FFFF)) begin
      ovf      = 1'b1;
      quotient = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (neg_r && (a_r > 64'h0000_0000_8000_0000)) begin
      ovf      = 1'b1;
      quotient = {1'b1, {(DATA_W-1){1'b0}}};
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule

/* hdl/nvi_dp.sv */
// datapath: point tables, tableau registers, search, update arithmetic and result register
module nvi_dp
  import nvi_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nvi_cmd_t                      cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] idx,
  input  logic [$clog2(MAX_POINTS)-1:0] m_idx,
  input  logic [SLOT_W-1:0]             in_slot,
  input  logic [DATA_W-1:0]             in_x,
  input  logic [DATA_W-1:0]             in_y,
  output nvi_sts_t                      sts,
  output logic [$clog2(MAX_POINTS)-1:0] near,
  output logic [DATA_W-1:0]             y_result,
  output logic                          error_flag
);

  localparam int unsigned IW = $clog2(MAX_POINTS);

  logic [DATA_W-1:0] xa_r [MAX_POINTS];
  logic [DATA_W-1:0] ya_r [MAX_POINTS];
  logic [DATA_W-1:0] cc_r [MAX_POINTS];
  logic [DATA_W-1:0] dd_r [MAX_POINTS];

  logic [DATA_W-1:0] x_r, y_r, xl_r, xh_r, cw_r, w_r, hl_r, hh_r;
  logic [DATA_W:0]   den_r, best_r;
  logic [IW-1:0]     near_r;
  logic              err_r;
  logic signed [63:0] prod_r;
  logic [DATA_W-1:0] yres_r;
  logic              eres_r;

  logic [IW+SLOT_W-1:0] slot_w;
  logic                 slot_ok;
  logic [IW-1:0]        slot_i;
  logic [IW-1:0]        idx_p1, idx_pm, near_mm;
  logic [DATA_W:0]      sdiff, dst, wdiff, hdiff, ydiff, ysum, den_c;
  logic [DATA_W-1:0]    sel_xa, y_add;
  logic                 near_ge;
  logic                 div_done, div_busy, div_ovf;
  logic [DATA_W-1:0]    div_q;

  assign slot_w  = {{IW{1'b0}}, in_slot};
  assign slot_ok = slot_w < (IW+SLOT_W)'(MAX_POINTS);
  assign slot_i  = slot_w[IW-1:0];

  assign idx_p1  = idx + IW'(1);
  assign idx_pm  = idx + m_idx;
  assign near_ge = near_r >= m_idx;
  assign near_mm = near_r - m_idx;

  // distance from x for the nearest-point search
  assign sel_xa = cmd.start ? xa_r[0] : xa_r[idx];
  always_comb begin
    if (cmd.start) sdiff = {in_x[DATA_W-1], in_x} - {sel_xa[DATA_W-1], sel_xa};
    else           sdiff = {x_r[DATA_W-1], x_r} - {sel_xa[DATA_W-1], sel_xa};
    dst = sdiff[DATA_W] ? -sdiff : sdiff;
  end

  assign wdiff = {cw_r[DATA_W-1], cw_r} - {dd_r[idx][DATA_W-1], dd_r[idx]};
  // rd_b takes x_a[i] - x, rd_c takes x_a[i+m] - x
  always_comb begin
    if (cmd.rd_b) hdiff = {xl_r[DATA_W-1], xl_r} - {x_r[DATA_W-1], x_r};
    else          hdiff = {xh_r[DATA_W-1], xh_r} - {x_r[DATA_W-1], x_r};
  end
  assign den_c = {xl_r[DATA_W-1], xl_r} - {xh_r[DATA_W-1], xh_r};

  assign y_add = near_ge ? dd_r[near_mm] : cc_r[0];
  assign ysum  = {y_r[DATA_W-1], y_r} + {y_add[DATA_W-1], y_add};
  assign ydiff = ysum;

  nvi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q),
    .ovf      (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (cmd.load && slot_ok) begin
      xa_r[slot_i] <= in_x;
      ya_r[slot_i] <= in_y;
    end
    if (cmd.start) begin
      x_r    <= in_x;
      err_r  <= 1'b0;
      near_r <= '0;
      best_r <= dst;
    end
    if (cmd.srch && (dst < best_r)) begin
      best_r <= dst;
      near_r <= idx;
    end
    if (cmd.init) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        cc_r[k] <= ya_r[k];
        dd_r[k] <= ya_r[k];
      end
      y_r <= ya_r[near_r];
    end
    if (cmd.rd_a) begin
      xl_r <= xa_r[idx];
      cw_r <= cc_r[idx_p1];
    end
    if (cmd.rd_b) begin
      xh_r  <= xa_r[idx_pm];
      w_r   <= sat33(wdiff);
      hl_r  <= sat33(hdiff);
      err_r <= err_r | ovf33(wdiff) | ovf33(hdiff);
    end
    if (cmd.rd_c) begin
      hh_r  <= sat33(hdiff);
      den_r <= den_c;
      err_r <= err_r | ovf33(hdiff);
    end
    if (cmd.zero) begin
      dd_r[idx] <= '0;
      cc_r[idx] <= '0;
      err_r     <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= cmd.mul_hl ? $signed(hl_r) * $signed(w_r) : $signed(hh_r) * $signed(w_r);
    end
    if (cmd.wr_d) begin
      dd_r[idx] <= div_q;
      err_r     <= err_r | div_ovf;
    end
    if (cmd.wr_c) begin
      cc_r[idx] <= div_q;
      err_r     <= err_r | div_ovf;
    end
    if (cmd.y_upd) begin
      y_r   <= sat33(ydiff);
      err_r <= err_r | ovf33(ydiff);
    end
    if (cmd.out_load) begin
      yres_r <= y_r;
      eres_r <= err_r;
    end
  end

  assign sts.den_zero = (den_r == '0);
  assign sts.div_done = div_done;
  assign sts.div_busy = div_busy;
  assign near         = near_r;
  assign y_result     = yres_r;
  assign error_flag   = eres_r;

endmodule

/* hdl/nvi_ctrl.sv */
// controller: sequences search, tableau updates and result hand-off
module nvi_ctrl
  import nvi_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [PC_W-1:0]               point_count,
  input  logic                          in_valid,
  input  logic                          in_req_type,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  nvi_sts_t                      sts,
  output nvi_cmd_t                      cmd,
  output logic [$clog2(MAX_POINTS)-1:0] idx,
  output logic [$clog2(MAX_POINTS)-1:0] m_idx
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_INIT = 4'd2;
  localparam logic [3:0] S_RDA  = 4'd3;
  localparam logic [3:0] S_RDB  = 4'd4;
  localparam logic [3:0] S_RDC  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_MULD = 4'd7;
  localparam logic [3:0] S_DVSD = 4'd8;
  localparam logic [3:0] S_DVWD = 4'd9;
  localparam logic [3:0] S_MULC = 4'd10;
  localparam logic [3:0] S_DVSC = 4'd11;
  localparam logic [3:0] S_DVWC = 4'd12;
  localparam logic [3:0] S_YUPD = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, m_r, m_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ov_r, ov_nxt;
  logic [PC_W:0] pc_ext;
  logic          accept;

  assign pc_ext = {1'b0, point_count};
  always_comb begin
    if (point_count == '0)                         n_nxt = CW'(1);
    else if (pc_ext > (PC_W+1)'(MAX_POINTS))      n_nxt = CW'(MAX_POINTS);
    else                                           n_nxt = CW'(point_count);
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    m_nxt     = m_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !in_req_type) begin
          cmd.load = 1'b1;
        end else if (accept) begin
          cmd.start = 1'b1;
          i_nxt     = IW'(1);
          state_nxt = (n_nxt == CW'(1)) ? S_INIT : S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        i_nxt    = i_r + IW'(1);
        if (CW'(i_r) + CW'(1) == n_r) state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.init  = 1'b1;
        i_nxt     = '0;
        m_nxt     = IW'(1);
        state_nxt = (n_r == CW'(1)) ? S_DONE : S_RDA;
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_RDC;
      end
      S_RDC: begin
        cmd.rd_c  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.den_zero) begin
          cmd.zero = 1'b1;
          if (CW'(i_r) + CW'(m_r) + CW'(1) < n_r) begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_RDA;
          end else begin
            state_nxt = S_YUPD;
          end
        end else begin
          state_nxt = S_MULD;
        end
      end
      S_MULD: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DVSD;
      end
      S_DVSD: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DVWD;
      end
      S_DVWD: begin
        if (sts.div_done) begin
          cmd.wr_d  = 1'b1;
          state_nxt = S_MULC;
        end
      end
      S_MULC: begin
        cmd.mul    = 1'b1;
        cmd.mul_hl = 1'b1;
        state_nxt  = S_DVSC;
      end
      S_DVSC: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DVWC;
      end
      S_DVWC: begin
        if (sts.div_done) begin
          cmd.wr_c = 1'b1;
          if (CW'(i_r) + CW'(m_r) + CW'(1) < n_r) begin
            i_nxt     = i_r + IW'(1);
            state_nxt = S_RDA;
          end else begin
            state_nxt = S_YUPD;
          end
        end
      end
      S_YUPD: begin
        cmd.y_upd = 1'b1;
        i_nxt     = '0;
        m_nxt     = m_r + IW'(1);
        state_nxt = (CW'(m_r) + CW'(1) < n_r) ? S_RDA : S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      i_r     <= '0;
      m_r     <= '0;
      n_r     <= CW'(1);
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      i_r     <= i_nxt;
      m_r     <= m_nxt;
      if (cmd.start) n_r <= n_nxt;
    end
  end

  assign out_valid = ov_r;
  assign idx       = i_r;
  assign m_idx     = m_r;

endmodule

/* hdl/neville_polynomial_interpolator.sv */
// top level of the neville polynomial interpolator
//
//  channel  dir   handshake        transaction
//  in_ch    in    valid/ready      load one point (req_type 0) or query at x (req_type 1)
//  out_ch   out   valid/ready      interpolated y and error flag, one per query
//  apb      in    psel/penable     point_count at byte address 0
//
// a query runs the nearest-point search over the n points and then the tableau updates;
// each tableau update runs the shared divider twice, and an update on equal abscissas
// skips the multiplier and divider, zeroes its entries and flags an error.
// one item is worked on at a time.
// rst_n is synchronous; it resets the control state and sets point_count to 4,
// the point tables hold whatever was loaded. a result waiting in the output
// register does not stop the next item from being taken.
module neville_polynomial_interpolator
  import nvi_pkg::*;
#(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nvi_in_if.sink      in_ch,
  nvi_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IW = $clog2(MAX_POINTS);

  logic [PC_W-1:0] pc_r;
  nvi_cmd_t        cmd;
  nvi_sts_t        sts;
  logic [IW-1:0]   idx, m_idx, near;
  logic [DATA_W-1:0] y_res;

  // config register: point_count at its byte address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
    end else if (psel && penable && pwrite && (paddr == 2'(REG_POINT_COUNT * 4))) begin
      pc_r <= pwdata[PC_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {{(32-PC_W){1'b0}}, pc_r};

  nvi_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_count (pc_r),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd),
    .idx         (idx),
    .m_idx       (m_idx)
  );

  nvi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .idx        (idx),
    .m_idx      (m_idx),
    .in_slot    (in_ch.point_index),
    .in_x       (in_ch.x_value),
    .in_y       (in_ch.y_value),
    .sts        (sts),
    .near       (near),
    .y_result   (y_res),
    .error_flag (out_ch.error_flag)
  );

  assign out_ch.y_result = y_res;

  // a query keeps the input side busy on the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type) |=> !in_ch.ready)
    else $error("input taken while a query is running");

  // the divider is never restarted mid-run
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  // results only overwrite a free or departing output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // the nearest point stays inside the point table of MAX_POINTS entries
  a_near_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_upd |-> (near < IW'(MAX_POINTS - 1) || near == IW'(MAX_POINTS - 1)))
    else $error("nearest index out of range");

endmodule
